>>> design/bbsj_pkg.sv
// Shared types and constants of the random-access Blum Blum Shub generator.
package bbsj_pkg;

  localparam int VAL_W      = 32;
  localparam int POS_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int RED_BITS   = 2;
  localparam int RED_CYCLES = POS_W / RED_BITS;
  localparam int RCNT_W     = $clog2(RED_CYCLES);

  typedef logic [VAL_W-1:0] word_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PRIME_MODULUS   = 2'd0;
  localparam cfg_idx_t REG_PRIME_TOTIENT   = 2'd1;
  localparam cfg_idx_t REG_TOTIENT_TOTIENT = 2'd2;

  localparam word_t PRIME_MODULUS_RST   = 32'd4294967087;
  localparam word_t PRIME_TOTIENT_RST   = 32'd4294967086;
  localparam word_t TOTIENT_TOTIENT_RST = 32'd2147483542;

  localparam word_t BASE_THREE = 32'd3;
  localparam word_t ONE_WORD   = 32'd1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_RED   = 8'b0000_0100,
    S_NEXT  = 8'b0000_1000,
    S_PSTEP = 8'b0001_0000,
    S_QSTEP = 8'b0010_0000,
    S_FETCH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_SEED  = 3'd0,
    PH_SQ    = 3'd1,
    PH_POS   = 3'd2,
    PH_BASE0 = 3'd3,
    PH_ACC3  = 3'd4,
    PH_BASE3 = 3'd5,
    PH_ACCS  = 3'd6
  } phase_t;

endpackage

>>> design/bbsj_cfg_if.sv
// Configuration write channel carrying a register index and its data word.
interface bbsj_cfg_if;
  logic               valid;
  logic               ready;
  bbsj_pkg::cfg_idx_t index;
  bbsj_pkg::word_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bbsj_in_if.sv
// Input channel carrying one load or evaluate word.
interface bbsj_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  bbsj_pkg::word_t seed_value;
  bbsj_pkg::pos_t  position;
  modport source (output valid, output kind, output seed_value, output position, input ready);
  modport sink   (input valid, input kind, input seed_value, input position, output ready);
endinterface

>>> design/bbsj_out_if.sv
// Result channel carrying one generator value word.
interface bbsj_out_if;
  logic            valid;
  logic            ready;
  bbsj_pkg::word_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> design/bbs_jump_modexp.sv
// Top level of the random-access Blum Blum Shub generator with one shared multiply-reduce unit.
// Each modular multiply runs the multiplier state, a reducer that takes two product bits per step
// and a sequencing state. A load reduces the seed and squares it EXP_BITS-1 times; an evaluate
// reduces the position, raises three to it and multiplies in one stored square per set bit of q.
// One word is worked on at a time; a waiting result does not block the next input word.
// Synchronous reset restores the register defaults and makes the square store read as zero.
module bbs_jump_modexp #(
  parameter int EXP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bbsj_cfg_if.sink    cfg_ch,
  bbsj_in_if.sink     in_ch,
  bbsj_out_if.source  out_ch
);

  localparam int IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EXP_BITS - 1);
  localparam bbsj_pkg::word_t EXP_MASK = (EXP_BITS >= bbsj_pkg::VAL_W) ? '1 :
    bbsj_pkg::VAL_W'((64'd1 << EXP_BITS) - 64'd1);
  localparam logic [bbsj_pkg::RCNT_W-1:0] RCNT_LAST =
    bbsj_pkg::RCNT_W'(bbsj_pkg::RED_CYCLES - 1);

  bbsj_pkg::state_t state_r, state_nxt;
  bbsj_pkg::phase_t phase_r, phase_nxt;
  bbsj_pkg::word_t  prime_r, tot_r, tottot_r;
  bbsj_pkg::pos_t   div_r, div_nxt;
  bbsj_pkg::word_t  rem_r, rem_nxt;
  bbsj_pkg::word_t  mod_r, mod_nxt;
  logic [bbsj_pkg::RCNT_W-1:0] cnt_r, cnt_nxt;
  bbsj_pkg::word_t  opa_r, opa_nxt, opb_r, opb_nxt;
  bbsj_pkg::word_t  base_r, base_nxt, acc_r, acc_nxt, bits_r, bits_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             loaded_r, loaded_nxt;
  bbsj_pkg::word_t  rd_r;
  logic             out_valid_r, out_valid_nxt;
  bbsj_pkg::word_t  out_value_r, out_value_nxt;
  logic             st_we;
  logic             in_acc;

  bbsj_pkg::word_t  store_mem [EXP_BITS];

  bbsj_pkg::word_t  opb_eff;
  bbsj_pkg::pos_t   prod;
  bbsj_pkg::word_t  rem_step;
  bbsj_pkg::pos_t   div_step;

  assign cfg_ch.ready  = 1'b1;
  assign in_ch.ready   = (state_r == bbsj_pkg::S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign in_acc        = in_ch.valid && in_ch.ready;

  assign opb_eff = (phase_r == bbsj_pkg::PH_ACCS) ? (loaded_r ? rd_r : '0) : opb_r;
  assign prod    = bbsj_pkg::POS_W'(opa_r) * bbsj_pkg::POS_W'(opb_eff);

  always_comb begin
    logic [bbsj_pkg::VAL_W:0] trial;
    trial    = '0;
    rem_step = rem_r;
    div_step = div_r;
    for (int k = 0; k < bbsj_pkg::RED_BITS; k++) begin
      trial    = {rem_step, div_step[bbsj_pkg::POS_W-1]};
      div_step = {div_step[bbsj_pkg::POS_W-2:0], 1'b0};
      if (trial >= {1'b0, mod_r}) begin
        trial = trial - {1'b0, mod_r};
      end
      rem_step = trial[bbsj_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    mod_nxt       = mod_r;
    cnt_nxt       = cnt_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    bits_nxt      = bits_r;
    idx_nxt       = idx_r;
    loaded_nxt    = loaded_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    st_we         = 1'b0;
    case (state_r)
      bbsj_pkg::S_IDLE: begin
        if (in_acc) begin
          rem_nxt = '0;
          cnt_nxt = '0;
          idx_nxt = '0;
          state_nxt = bbsj_pkg::S_RED;
          if (in_ch.kind) begin
            div_nxt   = in_ch.position;
            mod_nxt   = tottot_r;
            phase_nxt = bbsj_pkg::PH_POS;
          end else begin
            div_nxt   = {{(bbsj_pkg::POS_W - bbsj_pkg::VAL_W){1'b0}}, in_ch.seed_value};
            mod_nxt   = prime_r;
            phase_nxt = bbsj_pkg::PH_SEED;
          end
        end
      end
      bbsj_pkg::S_MUL: begin
        div_nxt   = prod;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = bbsj_pkg::S_RED;
      end
      bbsj_pkg::S_RED: begin
        if (mod_r == '0) begin
          rem_nxt   = div_r[bbsj_pkg::VAL_W-1:0];
          state_nxt = bbsj_pkg::S_NEXT;
        end else begin
          rem_nxt = rem_step;
          div_nxt = div_step;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == RCNT_LAST) begin
            state_nxt = bbsj_pkg::S_NEXT;
          end
        end
      end
      bbsj_pkg::S_NEXT: begin
        case (phase_r)
          bbsj_pkg::PH_SEED, bbsj_pkg::PH_SQ: begin
            st_we     = 1'b1;
            opa_nxt   = rem_r;
            opb_nxt   = rem_r;
            mod_nxt   = prime_r;
            phase_nxt = bbsj_pkg::PH_SQ;
            if (idx_r == LAST_IDX) begin
              loaded_nxt = 1'b1;
              state_nxt  = bbsj_pkg::S_IDLE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = bbsj_pkg::S_MUL;
            end
          end
          bbsj_pkg::PH_POS: begin
            bits_nxt  = rem_r & EXP_MASK;
            div_nxt   = {{(bbsj_pkg::POS_W - bbsj_pkg::VAL_W){1'b0}}, bbsj_pkg::BASE_THREE};
            mod_nxt   = tot_r;
            rem_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = bbsj_pkg::PH_BASE0;
            state_nxt = bbsj_pkg::S_RED;
          end
          bbsj_pkg::PH_BASE0: begin
            base_nxt  = rem_r;
            acc_nxt   = bbsj_pkg::ONE_WORD;
            state_nxt = bbsj_pkg::S_PSTEP;
          end
          bbsj_pkg::PH_ACC3: begin
            acc_nxt     = rem_r;
            bits_nxt[0] = 1'b0;
            state_nxt   = bbsj_pkg::S_PSTEP;
          end
          bbsj_pkg::PH_BASE3: begin
            base_nxt  = rem_r;
            bits_nxt  = bits_r >> 1;
            state_nxt = bbsj_pkg::S_PSTEP;
          end
          bbsj_pkg::PH_ACCS: begin
            acc_nxt   = rem_r;
            bits_nxt  = bits_r >> 1;
            idx_nxt   = idx_r + 1'b1;
            state_nxt = bbsj_pkg::S_QSTEP;
          end
          default: begin
            state_nxt = bbsj_pkg::S_IDLE;
          end
        endcase
      end
      bbsj_pkg::S_PSTEP: begin
        mod_nxt = tot_r;
        if (bits_r == '0) begin
          bits_nxt  = acc_r & EXP_MASK;
          acc_nxt   = bbsj_pkg::ONE_WORD;
          idx_nxt   = '0;
          state_nxt = bbsj_pkg::S_QSTEP;
        end else if (bits_r[0]) begin
          opa_nxt   = acc_r;
          opb_nxt   = base_r;
          phase_nxt = bbsj_pkg::PH_ACC3;
          state_nxt = bbsj_pkg::S_MUL;
        end else begin
          opa_nxt   = base_r;
          opb_nxt   = base_r;
          phase_nxt = bbsj_pkg::PH_BASE3;
          state_nxt = bbsj_pkg::S_MUL;
        end
      end
      bbsj_pkg::S_QSTEP: begin
        if (bits_r == '0) begin
          state_nxt = bbsj_pkg::S_DONE;
        end else if (bits_r[0]) begin
          opa_nxt   = acc_r;
          mod_nxt   = prime_r;
          phase_nxt = bbsj_pkg::PH_ACCS;
          state_nxt = bbsj_pkg::S_FETCH;
        end else begin
          bits_nxt = bits_r >> 1;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      bbsj_pkg::S_FETCH: begin
        state_nxt = bbsj_pkg::S_MUL;
      end
      bbsj_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_value_nxt = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = bbsj_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bbsj_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbsj_pkg::S_IDLE;
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      prime_r     <= bbsj_pkg::PRIME_MODULUS_RST;
      tot_r       <= bbsj_pkg::PRIME_TOTIENT_RST;
      tottot_r    <= bbsj_pkg::TOTIENT_TOTIENT_RST;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          bbsj_pkg::REG_PRIME_MODULUS:   prime_r  <= cfg_ch.data;
          bbsj_pkg::REG_PRIME_TOTIENT:   tot_r    <= cfg_ch.data;
          bbsj_pkg::REG_TOTIENT_TOTIENT: tottot_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    mod_r       <= mod_nxt;
    cnt_r       <= cnt_nxt;
    opa_r       <= opa_nxt;
    opb_r       <= opb_nxt;
    base_r      <= base_nxt;
    acc_r       <= acc_nxt;
    bits_r      <= bits_nxt;
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[idx_r] <= rem_r;
    end
    if (state_r == bbsj_pkg::S_FETCH) begin
      rd_r <= store_mem[idx_r];
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input accepted again while a word is in progress");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbsj_pkg::S_RED && mod_r != '0) |-> (rem_r < mod_r))
    else $error("reducer remainder not below the modulus");

  a_loaded_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |=> loaded_r)
    else $error("square store lost its loaded mark");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == bbsj_pkg::S_DONE))
    else $error("result word raised outside the finishing step");

endmodule

>>> bench/bbsj_checker.sv
// Checker for the jump generator: predicts every result word and compares it with the block.
`timescale 1ns / 100ps
module bbsj_checker #(
  parameter int EXP_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  bbsj_cfg_if  cfg_mon,
  bbsj_in_if   in_mon,
  bbsj_out_if  out_mon,
  output int   outstanding,
  output int   errors,
  output int   values_checked
);

  bbsj_pkg::word_t mod_value;
  bbsj_pkg::word_t mod_power;
  bbsj_pkg::word_t mod_position;
  bbsj_pkg::word_t squares [EXP_BITS];
  bbsj_pkg::word_t predicted_values [$];

  function automatic bbsj_pkg::word_t reduce_word(input bbsj_pkg::pos_t x,
                                                  input bbsj_pkg::word_t m);
    bbsj_pkg::pos_t rem;
    if (m == '0) return x[bbsj_pkg::VAL_W-1:0];
    rem = x % {32'b0, m};
    return rem[bbsj_pkg::VAL_W-1:0];
  endfunction

  function automatic bbsj_pkg::word_t mulmod(input bbsj_pkg::word_t a,
                                             input bbsj_pkg::word_t b,
                                             input bbsj_pkg::word_t m);
    bbsj_pkg::pos_t prod;
    prod = {32'b0, a} * {32'b0, b};
    return reduce_word(prod, m);
  endfunction

  function automatic bbsj_pkg::word_t three_power(input bbsj_pkg::word_t e);
    bbsj_pkg::word_t acc;
    bbsj_pkg::word_t base;
    bbsj_pkg::word_t bits;
    acc  = bbsj_pkg::ONE_WORD;
    base = reduce_word({32'b0, bbsj_pkg::BASE_THREE}, mod_power);
    bits = e;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (bits[0]) acc = mulmod(acc, base, mod_power);
      base = mulmod(base, base, mod_power);
      bits = bits >> 1;
      if (bits == '0) break;
    end
    return acc;
  endfunction

  function automatic void fill_squares(input bbsj_pkg::word_t seed);
    bbsj_pkg::word_t r;
    r = reduce_word({32'b0, seed}, mod_value);
    squares[0] = r;
    for (int i = 1; i < EXP_BITS; i++) begin
      r = mulmod(r, r, mod_value);
      squares[i] = r;
    end
  endfunction

  function automatic bbsj_pkg::word_t jump_value(input bbsj_pkg::pos_t pos);
    bbsj_pkg::word_t q;
    bbsj_pkg::word_t acc;
    q   = three_power(reduce_word(pos, mod_position));
    acc = bbsj_pkg::ONE_WORD;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (q[0]) acc = mulmod(acc, squares[i], mod_value);
      q = q >> 1;
      if (q == '0) break;
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input bbsj_pkg::word_t got,
                                 input bbsj_pkg::word_t want);
    $display("%0t ns: %s: got %08h, predicted %08h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    bbsj_pkg::word_t want;
    if (!rst_n) begin
      mod_value    = bbsj_pkg::PRIME_MODULUS_RST;
      mod_power    = bbsj_pkg::PRIME_TOTIENT_RST;
      mod_position = bbsj_pkg::TOTIENT_TOTIENT_RST;
      foreach (squares[i]) squares[i] = '0;
      predicted_values.delete();
      errors         = 0;
      values_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_values.size() == 0) begin
          report_mismatch("result word with no evaluate outstanding", out_mon.value, '0);
        end else begin
          want = predicted_values.pop_front();
          values_checked++;
          if (out_mon.value !== want) report_mismatch("value", out_mon.value, want);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          bbsj_pkg::REG_PRIME_MODULUS:   mod_value    = cfg_mon.data;
          bbsj_pkg::REG_PRIME_TOTIENT:   mod_power    = cfg_mon.data;
          bbsj_pkg::REG_TOTIENT_TOTIENT: mod_position = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind) predicted_values.push_back(jump_value(in_mon.position));
        else fill_squares(in_mon.seed_value);
      end
    end
    outstanding <= predicted_values.size();
  end

endmodule

>>> bench/tb_bbs_jump_modexp.sv
// Bench top for the jump generator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_bbs_jump_modexp;

  localparam int   EXP_BITS      = 32;
  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_EVAL     = 1'b1;
  localparam int   SETTLE_CYCLES = 3600;
  localparam int   HOLD_CYCLES   = 6000;
  localparam int   STALL_LIMIT   = 60000;

  logic  clk = 1'b0;
  logic  rst_n;
  int    tx_idle_pct = 31;
  int    rx_idle_pct = 59;
  int    hold_requests = 0;
  int    holds_served = 0;
  int    loads_sent = 0;
  int    evals_sent = 0;
  int    settings_used = 1;
  bbsj_pkg::word_t cur_tt = bbsj_pkg::TOTIENT_TOTIENT_RST;
  int    chk_outstanding;
  int    chk_errors;
  int    chk_values;

  bbsj_cfg_if cfg_ch ();
  bbsj_in_if  in_ch ();
  bbsj_out_if out_ch ();

  bbs_jump_modexp #(.EXP_BITS(EXP_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bbsj_checker #(.EXP_BITS(EXP_BITS)) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_mon        (cfg_ch),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .outstanding    (chk_outstanding),
    .errors         (chk_errors),
    .values_checked (chk_values)
  );

  always #6 clk = ~clk;

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bbsj_pkg::pos_t pick_position();
    case ($urandom_range(4))
      0: return {32'b0, $urandom_range(64)};
      1: return {32'b0, cur_tt} * $urandom_range(1000) + $urandom_range(2);
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic bbsj_pkg::word_t pick_seed();
    case ($urandom_range(3))
      0: return bbsj_pkg::word_t'($urandom_range(3));
      1: return ~bbsj_pkg::word_t'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // A load carries its seed in the low half of the operand; the unused field gets noise.
  task automatic send_word(input logic kind, input bbsj_pkg::pos_t operand);
    while (roll(tx_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    if (kind == KIND_LOAD) begin
      in_ch.seed_value <= operand[bbsj_pkg::VAL_W-1:0];
      in_ch.position   <= {$urandom, $urandom};
      loads_sent++;
    end else begin
      in_ch.seed_value <= $urandom;
      in_ch.position   <= operand;
      evals_sent++;
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 28) send_word(KIND_LOAD, {32'b0, pick_seed()});
      else send_word(KIND_EVAL, pick_position());
    end
  endtask

  // Loads give no result word, so the block is given its full latency before a write.
  task automatic new_setting(input bbsj_pkg::word_t pm, input bbsj_pkg::word_t pt,
                             input bbsj_pkg::word_t ptt);
    bbsj_pkg::cfg_idx_t regs [3];
    bbsj_pkg::word_t    vals [3];
    regs = '{bbsj_pkg::REG_PRIME_MODULUS, bbsj_pkg::REG_PRIME_TOTIENT,
             bbsj_pkg::REG_TOTIENT_TOTIENT};
    vals = '{pm, pt, ptt};
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = 0; r < 3; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[r];
      cfg_ch.data  <= vals[r];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    cur_tt = ptt;
    settings_used++;
  endtask

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_ch.ready <= !roll(rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles.", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= bbsj_pkg::REG_PRIME_MODULUS;
    cfg_ch.data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_LOAD;
    in_ch.seed_value <= '0;
    in_ch.position   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Evaluations against the cleared store come first.
    send_word(KIND_EVAL, 64'd0);
    send_word(KIND_EVAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(KIND_EVAL, 64'd1);
    send_word(KIND_LOAD, 64'd0);
    send_word(KIND_EVAL, 64'd5);
    send_word(KIND_LOAD, 64'h0000_0000_FFFF_FFFF);
    send_word(KIND_EVAL, 64'd0);
    send_word(KIND_EVAL, {32'b0, bbsj_pkg::TOTIENT_TOTIENT_RST});
    send_word(KIND_EVAL, {32'b0, bbsj_pkg::TOTIENT_TOTIENT_RST - 32'd1});
    send_word(KIND_EVAL, 64'h8000_0000_0000_0000);
    send_word(KIND_LOAD, 64'd1);
    send_word(KIND_EVAL, 64'h5555_5555_5555_5555);
    send_word(KIND_LOAD, 64'd2);
    send_word(KIND_EVAL, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(KIND_LOAD, 64'h0000_0000_8000_0000);
    send_word(KIND_EVAL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(KIND_LOAD, {32'b0, bbsj_pkg::PRIME_MODULUS_RST});
    send_word(KIND_EVAL, 64'd3);
    send_word(KIND_LOAD, {32'b0, bbsj_pkg::PRIME_MODULUS_RST + 32'd1});
    send_word(KIND_EVAL, 64'h0000_0001_0000_0000);
    send_word(KIND_LOAD, {32'b0, $urandom});
    send_word(KIND_EVAL, {$urandom, $urandom});
    send_random(70);

    // Small safe prime; the receiver holds off long enough for the input to back up.
    new_setting(32'd23, 32'd22, 32'd10);
    hold_requests++;
    send_random(45);

    tx_idle_pct = 59;
    rx_idle_pct = 31;
    new_setting('0, '0, '0);
    send_random(40);
    new_setting(32'd1, 32'd1, 32'd1);
    send_random(25);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    new_setting(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF);
    send_random(40);
    new_setting(32'd2, 32'hFFFF_FFFF, 32'd2);
    send_random(30);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d load and %0d evaluate words over %0d modulus settings.",
             loads_sent, evals_sent, settings_used);
    $display("Compared %0d values with zero, unit, small and full-width moduli; %0d mismatches.",
             chk_values, chk_errors);
    if (chk_errors == 0 && chk_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
